@@ rtl/urhs_pkg.sv @@
// Shared types and codes for the undo/redo history stack.
// No dependencies; urhs_stk and the core import this package.
`default_nettype none

package urhs_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_RECORD = 2'd0;
    localparam opcode_t OP_UNDO   = 2'd1;
    localparam opcode_t OP_REDO   = 2'd2;
    localparam opcode_t OP_CLEAR  = 2'd3;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Per-stack pointer command; push and pop are never raised together
    typedef struct packed {
        logic push;
        logic pop;
        logic clr;
    } stk_cmd_t;

endpackage

`default_nettype wire

@@ rtl/urhs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module urhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/urhs_stk.sv @@
// Head pointer and fill count of one bounded circular stack.
// Depends on urhs_pkg (stk_cmd_t).
`default_nettype none

module urhs_stk #(
    parameter int DEPTH = 128
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire urhs_pkg::stk_cmd_t         cmd,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [$clog2(DEPTH+1)-1:0]      fill_next,
    output logic                            empty
);

    import urhs_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  head_dec;
    logic [FILL_W-1:0] fill_reg;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.clr)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (cmd.push)
        begin
            head_next = head_inc;
            // full stack: overwrite the oldest, fill stays at the top
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            head_next = head_dec;
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    assign wr_addr = head_reg;
    assign rd_addr = head_dec;
    assign empty   = (fill_reg == '0);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("stack fill count above depth");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop on one stack in the same cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !empty)
        else $error("pop from an empty stack");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && !cmd.clr) |=> (fill_reg == $past(fill_reg) - FILL_W'(1)))
        else $error("pop did not drop the fill count by one");

endmodule

`default_nettype wire

@@ rtl/undo_redo_history_stack_core.sv @@
// Undo/redo history: two bounded circular stacks of state words.
// An accepted item passes the RAM read register (stage 1) and then the output register before out_valid rises.
// Throughput: one item per cycle while out_ready holds, set by one write and one read port per stack RAM.
// Reset clears head pointers, fill counts and valid flags at once; no clearing pass.
// Stack RAM contents are undefined after reset and are read only after being written.
// Depends on urhs_pkg, urhs_stk and urhs_ram.
`default_nettype none

module undo_redo_history_stack_core #(
    parameter int DEPTH      = 128,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire urhs_pkg::opcode_t opcode,
    input  wire logic [31:0]       current_state,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   status,
    output logic [31:0]            restored_state,
    output logic [7:0]             undo_depth,
    output logic [7:0]             redo_depth
);

    import urhs_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic status;
        logic has_data;
        logic from_redo;
    } s1_ctl_t;

    logic             accept;
    logic             advance;
    stk_cmd_t         undo_cmd;
    stk_cmd_t         redo_cmd;
    logic [PTR_W-1:0] undo_wr_addr;
    logic [PTR_W-1:0] undo_rd_addr;
    logic [PTR_W-1:0] redo_wr_addr;
    logic [PTR_W-1:0] redo_rd_addr;
    logic [FILL_W-1:0] undo_fill_next;
    logic [FILL_W-1:0] redo_fill_next;
    logic             undo_empty;
    logic             redo_empty;
    logic             undo_we;
    logic             redo_we;
    logic             undo_re;
    logic             redo_re;
    logic [WORD_WIDTH-1:0] word;
    logic [WORD_WIDTH-1:0] undo_rdata;
    logic [WORD_WIDTH-1:0] redo_rdata;

    s1_ctl_t     s1_ctl_next;
    s1_ctl_t     s1_ctl_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_undo_depth_reg;
    logic [7:0]  s1_redo_depth_reg;

    logic        out_valid_reg;
    logic        status_reg;
    logic [31:0] restored_next;
    logic [31:0] restored_reg;
    logic [7:0]  undo_depth_reg;
    logic [7:0]  redo_depth_reg;

    assign accept  = in_valid && in_ready;
    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign word    = WORD_WIDTH'(current_state);

    always_comb
    begin
        undo_cmd    = '0;
        redo_cmd    = '0;
        undo_we     = 1'b0;
        redo_we     = 1'b0;
        undo_re     = 1'b0;
        redo_re     = 1'b0;
        s1_ctl_next = '0;
        if (accept)
        begin
            unique case (opcode)
                OP_RECORD:
                begin
                    redo_cmd.clr  = 1'b1;
                    undo_cmd.push = 1'b1;
                    undo_we       = 1'b1;
                end
                OP_UNDO:
                begin
                    if (undo_empty)
                    begin
                        s1_ctl_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        redo_cmd.push        = 1'b1;
                        redo_we              = 1'b1;
                        undo_cmd.pop         = 1'b1;
                        undo_re              = 1'b1;
                        s1_ctl_next.has_data = 1'b1;
                    end
                end
                OP_REDO:
                begin
                    if (redo_empty)
                    begin
                        s1_ctl_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        undo_cmd.push         = 1'b1;
                        undo_we               = 1'b1;
                        redo_cmd.pop          = 1'b1;
                        redo_re               = 1'b1;
                        s1_ctl_next.has_data  = 1'b1;
                        s1_ctl_next.from_redo = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    undo_cmd.clr = 1'b1;
                    redo_cmd.clr = 1'b1;
                end
            endcase
        end
    end

    urhs_stk #(
        .DEPTH (DEPTH)
    ) u_undo_stk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (undo_cmd),
        .wr_addr   (undo_wr_addr),
        .rd_addr   (undo_rd_addr),
        .fill_next (undo_fill_next),
        .empty     (undo_empty)
    );

    urhs_stk #(
        .DEPTH (DEPTH)
    ) u_redo_stk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (redo_cmd),
        .wr_addr   (redo_wr_addr),
        .rd_addr   (redo_rd_addr),
        .fill_next (redo_fill_next),
        .empty     (redo_empty)
    );

    urhs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_undo_ram (
        .clk   (clk),
        .we    (undo_we),
        .waddr (undo_wr_addr),
        .wdata (word),
        .re    (undo_re),
        .raddr (undo_rd_addr),
        .rdata (undo_rdata)
    );

    urhs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_redo_ram (
        .clk   (clk),
        .we    (redo_we),
        .waddr (redo_wr_addr),
        .wdata (word),
        .re    (redo_re),
        .raddr (redo_rd_addr),
        .rdata (redo_rdata)
    );

    // Stage 1: control and depths wait beside the RAM read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg        <= s1_ctl_next;
            s1_undo_depth_reg <= 8'(undo_fill_next);
            s1_redo_depth_reg <= 8'(redo_fill_next);
        end
    end

    always_comb
    begin
        restored_next = '0;
        if (s1_ctl_reg.has_data)
        begin
            restored_next = s1_ctl_reg.from_redo ? 32'(redo_rdata) : 32'(undo_rdata);
        end
    end

    // Output register: hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= s1_ctl_reg.status;
            restored_reg   <= restored_next;
            undo_depth_reg <= s1_undo_depth_reg;
            redo_depth_reg <= s1_redo_depth_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign restored_state = restored_reg;
    assign undo_depth     = undo_depth_reg;
    assign redo_depth     = redo_depth_reg;

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctl_reg.status) |-> !s1_ctl_reg.has_data)
        else $error("empty status paired with restored data");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_CLEAR)
            |=> (s1_undo_depth_reg == 8'd0 && s1_redo_depth_reg == 8'd0))
        else $error("clear left a nonzero depth");

    a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(undo_re && redo_re) && !(undo_we && redo_we))
        else $error("both stacks read or both written by one item");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("stage 1 dropped an item while the output was stalled");

endmodule

`default_nettype wire
